/* rtl/point_in_polygon_test_defines.svh */
// Assertion macros for the point-in-polygon classifier
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PIP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pip check failed");
`define PIP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pip check failed");
`else
`define PIP_ASSERT_NOW(lbl, ante, cons)
`define PIP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/pip_pkg.sv */
// Shared types and constants for the point-in-polygon classifier
package pip_pkg;

  typedef enum logic [1:0] {
    CLS_OUTSIDE = 2'd0,
    CLS_INSIDE  = 2'd1,
    CLS_ON      = 2'd2
  } cls_t;

  typedef logic [1:0] tally_t;

  localparam tally_t TALLY_MAX = 2'd3;

  // per-item control that rides along the pipeline
  typedef struct packed {
    logic a_en;      // edge from previous vertex to this one
    logic b_en;      // closing edge from this vertex to the first
    logic new_poly;  // item opens a polygon
    logic last;      // item closes the polygon, result due
    logic full;      // at least three vertices
  } ctl_t;

  // outcome of one edge test
  typedef struct packed {
    logic o_pos;
    logic o_zero;
    logic on_box;
    logic cur_above;
    logic prev_above;
  } edge_res_t;

endpackage

/* rtl/point_in_polygon_test.sv */
// Point-in-polygon classifier top level: handshake, pipeline control, edge units
// One vertex per cycle while the result register is free or out_ready is high; the
// pipeline is input register, split multiply stage, product sum stage, then
// compare/parity into the result register.
// Reset clears stage valids, the open-polygon count and the crossing parity.
`include "point_in_polygon_test_defines.svh"
module point_in_polygon_test import pip_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_query_x,
  input  logic signed [COORD_WIDTH-1:0] in_query_y,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_y,
  input  logic                          in_start_flag,
  input  logic                          in_end_flag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_classification
);

  localparam int W = COORD_WIDTH;

  logic signed [W-1:0] s0_qx, s0_qy, s0_pvx, s0_pvy, s0_cvx, s0_cvy, s0_fvx, s0_fvy;
  ctl_t      s0_ctl, ctl1_r, ctl2_r;
  logic      v0_r, v1_r, v2_r, v0_nxt, v1_nxt, v2_nxt;
  logic      rdy1, rdy2, en1, en2, in_accept;
  edge_res_t res_a, res_b;
  cls_t      out_cls;

  assign rdy1      = !v1_r || rdy2;
  assign in_ready  = !v0_r || rdy1;
  assign in_accept = in_valid && in_ready;
  assign en1       = v0_r && rdy1;
  assign en2       = v1_r && rdy2;

  assign v0_nxt = in_accept || (v0_r && !rdy1);
  assign v1_nxt = en1 || (v1_r && !rdy2);
  assign v2_nxt = en2 || (v2_r && !rdy2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ctl1_r <= s0_ctl;
    end
    if (en2) begin
      ctl2_r <= ctl1_r;
    end
  end

  pip_track #(.W(W)) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_accept),
    .query_x    (in_query_x),
    .query_y    (in_query_y),
    .vertex_x   (in_vertex_x),
    .vertex_y   (in_vertex_y),
    .start_flag (in_start_flag),
    .end_flag   (in_end_flag),
    .s0_qx      (s0_qx),
    .s0_qy      (s0_qy),
    .s0_pvx     (s0_pvx),
    .s0_pvy     (s0_pvy),
    .s0_cvx     (s0_cvx),
    .s0_cvy     (s0_cvy),
    .s0_fvx     (s0_fvx),
    .s0_fvy     (s0_fvy),
    .s0_ctl     (s0_ctl)
  );

  // previous vertex to this vertex
  pip_edge #(.W(W)) u_edge_a (
    .clk (clk),
    .en1 (en1),
    .en2 (en2),
    .ax  (s0_pvx),
    .ay  (s0_pvy),
    .bx  (s0_cvx),
    .by  (s0_cvy),
    .qx  (s0_qx),
    .qy  (s0_qy),
    .res (res_a)
  );

  // closing edge, used only on the last vertex
  pip_edge #(.W(W)) u_edge_b (
    .clk (clk),
    .en1 (en1),
    .en2 (en2),
    .ax  (s0_cvx),
    .ay  (s0_cvy),
    .bx  (s0_fvx),
    .by  (s0_fvy),
    .qx  (s0_qx),
    .qy  (s0_qy),
    .res (res_b)
  );

  pip_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_valid  (v2_r),
    .s2_ctl    (ctl2_r),
    .res_a     (res_a),
    .res_b     (res_b),
    .out_ready (out_ready),
    .s2_ready  (rdy2),
    .out_valid (out_valid),
    .out_cls   (out_cls)
  );

  assign out_classification = out_cls;

  `PIP_ASSERT_NEXT(a_s0_load, in_valid && in_ready, v0_r)
  `PIP_ASSERT_NEXT(a_s1_hold, v1_r && !rdy2, v1_r)
  `PIP_ASSERT_NOW(a_out_src, out_valid && !$past(out_valid), $past(v2_r && ctl2_r.last))
  `PIP_ASSERT_NEXT(a_short_out, v2_r && rdy2 && ctl2_r.last && !ctl2_r.full,
                   out_classification == CLS_OUTSIDE)

endmodule

/* rtl/pip_track.sv */
// Polygon tracker: holds first/previous vertex and query, loads the input stage
module pip_track import pip_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic signed [W-1:0] query_x,
  input  logic signed [W-1:0] query_y,
  input  logic signed [W-1:0] vertex_x,
  input  logic signed [W-1:0] vertex_y,
  input  logic                start_flag,
  input  logic                end_flag,
  output logic signed [W-1:0] s0_qx,
  output logic signed [W-1:0] s0_qy,
  output logic signed [W-1:0] s0_pvx,
  output logic signed [W-1:0] s0_pvy,
  output logic signed [W-1:0] s0_cvx,
  output logic signed [W-1:0] s0_cvy,
  output logic signed [W-1:0] s0_fvx,
  output logic signed [W-1:0] s0_fvy,
  output ctl_t                s0_ctl
);

  logic signed [W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r, held_x_r, held_y_r;
  logic signed [W-1:0] first_x_nxt, first_y_nxt, held_x_nxt, held_y_nxt;
  tally_t              tally_r, tally_inc;
  logic                new_poly;
  ctl_t                ctl_nxt;

  logic signed [W-1:0] qx_r, qy_r, pvx_r, pvy_r, cvx_r, cvy_r, fvx_r, fvy_r;
  ctl_t                ctl_r;

  // an item with no polygon open starts one, flag or not
  assign new_poly = start_flag || (tally_r == '0);

  always_comb begin
    first_x_nxt = new_poly ? vertex_x : first_x_r;
    first_y_nxt = new_poly ? vertex_y : first_y_r;
    held_x_nxt  = new_poly ? query_x  : held_x_r;
    held_y_nxt  = new_poly ? query_y  : held_y_r;
    if (new_poly) begin
      tally_inc = tally_t'(1);
    end else if (tally_r == TALLY_MAX) begin
      tally_inc = TALLY_MAX;
    end else begin
      tally_inc = tally_r + tally_t'(1);
    end
    ctl_nxt.a_en     = !new_poly;
    ctl_nxt.b_en     = end_flag;
    ctl_nxt.new_poly = new_poly;
    ctl_nxt.last     = end_flag;
    ctl_nxt.full     = (tally_inc == TALLY_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
    end else if (load) begin
      tally_r <= end_flag ? tally_t'(0) : tally_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      first_x_r <= first_x_nxt;
      first_y_r <= first_y_nxt;
      prev_x_r  <= vertex_x;
      prev_y_r  <= vertex_y;
      held_x_r  <= held_x_nxt;
      held_y_r  <= held_y_nxt;
      qx_r      <= held_x_nxt;
      qy_r      <= held_y_nxt;
      pvx_r     <= prev_x_r;
      pvy_r     <= prev_y_r;
      cvx_r     <= vertex_x;
      cvy_r     <= vertex_y;
      fvx_r     <= first_x_nxt;
      fvy_r     <= first_y_nxt;
      ctl_r     <= ctl_nxt;
    end
  end

  assign s0_qx  = qx_r;
  assign s0_qy  = qy_r;
  assign s0_pvx = pvx_r;
  assign s0_pvy = pvy_r;
  assign s0_cvx = cvx_r;
  assign s0_cvy = cvy_r;
  assign s0_fvx = fvx_r;
  assign s0_fvy = fvy_r;
  assign s0_ctl = ctl_r;

endmodule

/* rtl/pip_edge.sv */
// Edge test datapath: split cross-product multiplies, sum, exact sign compare
module pip_edge import pip_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                en1,
  input  logic                en2,
  input  logic signed [W-1:0] ax,
  input  logic signed [W-1:0] ay,
  input  logic signed [W-1:0] bx,
  input  logic signed [W-1:0] by,
  input  logic signed [W-1:0] qx,
  input  logic signed [W-1:0] qy,
  output edge_res_t           res
);

  localparam int D  = W + 1;        // difference width
  localparam int H  = (D + 1) / 2;  // low half, unsigned
  localparam int HI = D - H;        // high half, signed
  localparam int PW = 2 * D;        // full product width
  localparam int MW = HI + H + 1;   // cross partial width

  logic signed [D-1:0]  m1, m2, m3, m4;
  logic signed [D-1:0]  opa [2];
  logic signed [D-1:0]  opb [2];
  logic signed [PW-1:0] prod [2];

  logic box_x, box_y;
  logic on_box_r, cur_above_r, prev_above_r;
  logic on_box2_r, cur_above2_r, prev_above2_r;

  // cross = (b - a).x * (q - b).y - (b - a).y * (q - b).x
  assign m1 = $signed({bx[W-1], bx}) - $signed({ax[W-1], ax});
  assign m2 = $signed({qy[W-1], qy}) - $signed({by[W-1], by});
  assign m3 = $signed({by[W-1], by}) - $signed({ay[W-1], ay});
  assign m4 = $signed({qx[W-1], qx}) - $signed({bx[W-1], bx});

  assign opa[0] = m1;
  assign opb[0] = m2;
  assign opa[1] = m3;
  assign opb[1] = m4;

  // closed bounding box of the edge
  assign box_x = ((ax < bx) ? (qx >= ax && qx <= bx) : (qx >= bx && qx <= ax));
  assign box_y = ((ay < by) ? (qy >= ay && qy <= by) : (qy >= by && qy <= ay));

  for (genvar g = 0; g < 2; g++) begin : g_prod
    logic        [H-1:0]    al, bl;
    logic signed [HI-1:0]   ah, bh;
    logic        [2*H-1:0]  ll, ll_r;
    logic signed [MW-1:0]   lh, hl, lh_r, hl_r;
    logic signed [2*HI-1:0] hh, hh_r;
    logic signed [MW:0]     mid;
    logic        [PW-1:0]   llx, midx, hhx;
    logic signed [PW-1:0]   prod_r;

    assign al = opa[g][H-1:0];
    assign ah = opa[g][D-1:H];
    assign bl = opb[g][H-1:0];
    assign bh = opb[g][D-1:H];

    assign ll = {{H{1'b0}}, al} * {{H{1'b0}}, bl};
    assign lh = $signed({{(H+1){ah[HI-1]}}, ah}) * $signed({{(HI+1){1'b0}}, bl});
    assign hl = $signed({{(HI+1){1'b0}}, al}) * $signed({{(H+1){bh[HI-1]}}, bh});
    assign hh = $signed({{HI{ah[HI-1]}}, ah}) * $signed({{HI{bh[HI-1]}}, bh});

    always_ff @(posedge clk) begin
      if (en1) begin
        ll_r <= ll;
        lh_r <= lh;
        hl_r <= hl;
        hh_r <= hh;
      end
    end

    assign mid  = $signed({lh_r[MW-1], lh_r}) + $signed({hl_r[MW-1], hl_r});
    assign llx  = {{(PW-2*H){1'b0}}, ll_r};
    assign midx = {{(PW-MW-1-H){mid[MW]}}, mid, {H{1'b0}}};
    assign hhx  = {hh_r, {(2*H){1'b0}}};

    always_ff @(posedge clk) begin
      if (en2) begin
        prod_r <= $signed(hhx + midx + llx);
      end
    end

    assign prod[g] = prod_r;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      on_box_r     <= box_x && box_y;
      cur_above_r  <= (qy < by);
      prev_above_r <= (qy < ay);
    end
    if (en2) begin
      on_box2_r     <= on_box_r;
      cur_above2_r  <= cur_above_r;
      prev_above2_r <= prev_above_r;
    end
  end

  assign res.o_pos      = (prod[0] > prod[1]);
  assign res.o_zero     = (prod[0] == prod[1]);
  assign res.on_box     = on_box2_r;
  assign res.cur_above  = cur_above2_r;
  assign res.prev_above = prev_above2_r;

endmodule

/* rtl/pip_acc.sv */
// Parity and boundary accumulation, classification output register
module pip_acc import pip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s2_valid,
  input  ctl_t      s2_ctl,
  input  edge_res_t res_a,
  input  edge_res_t res_b,
  input  logic      out_ready,
  output logic      s2_ready,
  output logic      out_valid,
  output cls_t      out_cls
);

  typedef struct packed {
    logic on_seen;
    logic parity;
  } acc_t;

  function automatic acc_t edge_step(edge_res_t e, acc_t st);
    acc_t nx;
    logic hit;
    logic crossing;
    hit      = e.o_zero && e.on_box;
    crossing = (e.prev_above != e.cur_above) && (e.o_pos == e.cur_above);
    nx.on_seen = st.on_seen || hit;
    nx.parity  = st.parity ^ (!hit && crossing);
    return nx;
  endfunction

  acc_t acc_r, acc_base, acc_a, acc_nxt;
  logic out_valid_r;
  cls_t cls_r, cls_nxt;
  logic take;

  assign s2_ready = !s2_valid || !s2_ctl.last || !out_valid_r || out_ready;
  assign take     = s2_valid && s2_ready;

  always_comb begin
    acc_base = s2_ctl.new_poly ? acc_t'(0) : acc_r;
    acc_a    = s2_ctl.a_en ? edge_step(res_a, acc_base) : acc_base;
    acc_nxt  = s2_ctl.b_en ? edge_step(res_b, acc_a) : acc_a;
    if (!s2_ctl.full) begin
      cls_nxt = CLS_OUTSIDE;
    end else if (acc_nxt.on_seen) begin
      cls_nxt = CLS_ON;
    end else if (acc_nxt.parity) begin
      cls_nxt = CLS_INSIDE;
    end else begin
      cls_nxt = CLS_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        acc_r <= acc_nxt;
      end
      if (take && s2_ctl.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && s2_ctl.last) begin
      cls_r <= cls_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_cls   = cls_r;

endmodule

/* verif/tb_top.sv */
// Testbench for point_in_polygon_test: streamed polygons checked against a local classifier
module tb_top import pip_pkg::*; ();

  localparam int CW = 32;
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [CW-1:0] in_query_x;
  logic signed [CW-1:0] in_query_y;
  logic signed [CW-1:0] in_vertex_x;
  logic signed [CW-1:0] in_vertex_y;
  logic                 in_start_flag;
  logic                 in_end_flag;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_classification;

  point_in_polygon_test #(.COORD_WIDTH(CW)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_query_x        (in_query_x),
    .in_query_y        (in_query_y),
    .in_vertex_x       (in_vertex_x),
    .in_vertex_y       (in_vertex_y),
    .in_start_flag     (in_start_flag),
    .in_end_flag       (in_end_flag),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_classification(out_classification)
  );

  // classifier state, mirrors the block
  logic signed [CW-1:0] poly_first_x, poly_first_y;
  logic signed [CW-1:0] poly_prev_x, poly_prev_y;
  logic signed [CW-1:0] pt_x, pt_y;
  bit                   cross_parity;
  bit                   on_boundary;
  tally_t               vtx_count;

  cls_t cls_due[$];
  int   err_count;
  int   items_sent;
  bit   in_idle_on;
  bit   out_stall_on;
  int   stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exact sign of (b - a) x (p - b)
  function automatic int turn_sign(logic signed [CW-1:0] ax, ay, bx, by, px, py);
    logic signed [CW:0]       dx1, dy1, dx2, dy2;
    logic signed [2*CW+3:0]   lhs, rhs, d;
    dx1 = (CW+1)'(bx) - (CW+1)'(ax);
    dy1 = (CW+1)'(py) - (CW+1)'(by);
    dy2 = (CW+1)'(by) - (CW+1)'(ay);
    dx2 = (CW+1)'(px) - (CW+1)'(bx);
    lhs = (2*CW+4)'(dx1) * (2*CW+4)'(dy1);
    rhs = (2*CW+4)'(dy2) * (2*CW+4)'(dx2);
    d = lhs - rhs;
    if (d > 0) return 1;
    if (d == 0) return 0;
    return -1;
  endfunction

  function automatic bit in_span(logic signed [CW-1:0] v, a, b);
    logic signed [CW-1:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic void cross_edge(logic signed [CW-1:0] ax, ay, bx, by);
    int s;
    bit cur_above, prev_above;
    s = turn_sign(ax, ay, bx, by, pt_x, pt_y);
    if (s == 0 && in_span(pt_x, ax, bx) && in_span(pt_y, ay, by)) begin
      on_boundary = 1'b1;
    end else begin
      cur_above  = pt_y < by;
      prev_above = pt_y < ay;
      if (prev_above != cur_above && ((s > 0) == cur_above))
        cross_parity = ~cross_parity;
    end
  endfunction

  // update classifier state for one accepted item, queue the class it produces
  function automatic void classify_vertex(logic signed [CW-1:0] qx, qy, vx, vy,
                                          bit is_start, bit is_end);
    if (is_start || vtx_count == 0) begin
      pt_x = qx;
      pt_y = qy;
      poly_first_x = vx;
      poly_first_y = vy;
      poly_prev_x = vx;
      poly_prev_y = vy;
      cross_parity = 1'b0;
      on_boundary = 1'b0;
      vtx_count = 2'd1;
    end else begin
      cross_edge(poly_prev_x, poly_prev_y, vx, vy);
      poly_prev_x = vx;
      poly_prev_y = vy;
      if (vtx_count < TALLY_MAX) vtx_count++;
    end
    if (is_end) begin
      cross_edge(poly_prev_x, poly_prev_y, poly_first_x, poly_first_y);
      if (vtx_count < TALLY_MAX) cls_due.push_back(CLS_OUTSIDE);
      else if (on_boundary) cls_due.push_back(CLS_ON);
      else cls_due.push_back(cross_parity ? CLS_INSIDE : CLS_OUTSIDE);
      vtx_count = 2'd0;
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // in_valid stays high after acceptance; it only drops for an idle burst or a drain
  task automatic send_item(logic signed [CW-1:0] qx, qy, vx, vy, bit is_start, bit is_end);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_query_x    <= qx;
    in_query_y    <= qy;
    in_vertex_x   <= vx;
    in_vertex_y   <= vy;
    in_start_flag <= is_start;
    in_end_flag   <= is_end;
    do @(posedge clk); while (!in_ready);
    classify_vertex(qx, qy, vx, vy, is_start, is_end);
    items_sent++;
  endtask

  // hold off the sender until every pending class has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (cls_due.size() != 0);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (out_stall_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    cls_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cls_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", out_classification));
      end else begin
        want = cls_due.pop_front();
        if (out_classification !== want)
          report_mismatch($sformatf("classification %0d, want %0d",
                                    out_classification, want));
      end
    end
  end

  // no start flag right after reset still opens a polygon
  task automatic test_missing_start();
    send_item(32'sd2, 32'sd2, 32'sd0, 32'sd0, 1'b0, 1'b0);
    send_item($urandom, $urandom, 32'sd10, 32'sd0, 1'b0, 1'b0);
    send_item($urandom, $urandom, 32'sd0, 32'sd10, 1'b0, 1'b1);
  endtask

  // one- and two-vertex polygons are outside even with the point on them
  task automatic test_degenerate();
    send_item(32'sd5, 32'sd5, 32'sd5, 32'sd5, 1'b1, 1'b1);
    send_item(32'sd2, 32'sd2, 32'sd0, 32'sd0, 1'b1, 1'b0);
    send_item($urandom, $urandom, 32'sd4, 32'sd4, 1'b0, 1'b1);
  endtask

  // a start in the middle drops the open polygon without a result
  task automatic test_restart();
    send_item(32'sd100, 32'sd100, 32'sd0, 32'sd0, 1'b1, 1'b0);
    send_item($urandom, $urandom, 32'sd1, 32'sd1, 1'b0, 1'b0);
    send_item(32'sd1, 32'sd1, 32'sd0, 32'sd0, 1'b1, 1'b0);
    send_item($urandom, $urandom, 32'sd4, 32'sd0, 1'b0, 1'b0);
    send_item($urandom, $urandom, 32'sd0, 32'sd4, 1'b0, 1'b1);
  endtask

  task automatic test_extremes();
    // full-range square: center, then a point on the left edge
    send_item(32'sd0, 32'sd0, CMIN, CMIN, 1'b1, 1'b0);
    send_item(CMAX, CMIN, CMAX, CMIN, 1'b0, 1'b0);
    send_item(CMIN, CMAX, CMAX, CMAX, 1'b0, 1'b0);
    send_item(CMAX, CMAX, CMIN, CMAX, 1'b0, 1'b1);
    send_item(CMIN, 32'sd5, CMIN, CMIN, 1'b1, 1'b0);
    send_item(32'sd0, 32'sd0, CMAX, CMIN, 1'b0, 1'b0);
    send_item(32'sd0, 32'sd0, CMAX, CMAX, 1'b0, 1'b0);
    send_item(32'sd0, 32'sd0, CMIN, CMAX, 1'b0, 1'b1);
    // tiny square, point at the far corner of the range
    send_item(CMAX, CMIN, 32'sd0, 32'sd0, 1'b1, 1'b0);
    send_item(CMIN, CMAX, 32'sd2, 32'sd0, 1'b0, 1'b0);
    send_item(CMIN, CMAX, 32'sd2, 32'sd2, 1'b0, 1'b0);
    send_item(CMAX, CMIN, 32'sd0, 32'sd2, 1'b0, 1'b1);
  endtask

  function automatic logic signed [CW-1:0] pick_coord(int mode);
    case (mode)
      0: return $urandom_range(0, 8) - 4;
      1: return $urandom;
      default: return $urandom_range(0, 1) ? CMIN + $urandom_range(0, 3)
                                           : CMAX - $urandom_range(0, 3);
    endcase
  endfunction

  // mostly well-formed polygons; in a tenth, start/end flags may be flipped at random
  task automatic test_random_polygons(int n_items);
    logic signed [CW-1:0] px[8], py[8];
    logic signed [CW-1:0] qx, qy;
    int nv, mode, pick, stop_at;
    bit noisy, s, e;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      nv = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      pick = $urandom_range(0, 9);
      mode = (pick < 5) ? 0 : (pick < 8) ? 1 : 2;
      noisy = $urandom_range(0, 9) == 0;
      if (out_stall_on) in_idle_on = $urandom_range(0, 3) != 0;
      for (int i = 0; i < nv; i++) begin
        px[i] = pick_coord(mode);
        py[i] = pick_coord(mode);
      end
      case ($urandom_range(0, 3))
        0: begin
          pick = $urandom_range(0, nv - 1);
          qx = px[pick];
          qy = py[pick];
        end
        1: begin
          qx = CW'((33'(px[0]) + 33'(px[nv-1])) >>> 1);
          qy = CW'((33'(py[0]) + 33'(py[nv-1])) >>> 1);
        end
        default: begin
          qx = pick_coord(mode);
          qy = pick_coord(mode);
        end
      endcase
      for (int i = 0; i < nv; i++) begin
        s = (i == 0);
        e = (i == nv - 1);
        if (noisy && $urandom_range(0, 3) == 0) s = ~s;
        if (noisy && $urandom_range(0, 3) == 0) e = ~e;
        if (i == 0) send_item(qx, qy, px[i], py[i], s, e);
        else send_item($urandom, $urandom, px[i], py[i], s, e);
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_query_x    <= '0;
    in_query_y    <= '0;
    in_vertex_x   <= '0;
    in_vertex_y   <= '0;
    in_start_flag <= 1'b0;
    in_end_flag   <= 1'b0;
    out_ready     <= 1'b0;
    vtx_count     = 2'd0;
    cross_parity  = 1'b0;
    on_boundary   = 1'b0;
    poly_first_x  = '0;
    poly_first_y  = '0;
    poly_prev_x   = '0;
    poly_prev_y   = '0;
    pt_x          = '0;
    pt_y          = '0;
    err_count     = 0;
    items_sent    = 0;
    stall_left    = 0;
    in_idle_on    = 1'b1;
    out_stall_on  = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_missing_start();
    test_degenerate();
    test_restart();
    test_extremes();
    drain_results();
    test_random_polygons(300);
    drain_results();
    // closing stretch at full rate on both sides
    in_idle_on   = 1'b0;
    out_stall_on = 1'b0;
    test_random_polygons(80);

    in_valid <= 1'b0;
    while (cls_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/pip_pkg.sv
rtl/pip_track.sv
rtl/pip_edge.sv
rtl/pip_acc.sv
rtl/point_in_polygon_test.sv
verif/tb_top.sv
